### design/ifmt_pkg.sv
// shared types and constants of the integer decimal formatter
package ifmt_pkg;

    localparam int MAX_WIDTH  = 64;
    localparam int NUM_DIGITS = 20;
    localparam int QDEPTH     = 2;

    localparam logic [7:0] CHAR_ZERO  = 8'd48;
    localparam logic [7:0] CHAR_SPACE = 8'd32;
    localparam logic [7:0] CHAR_PLUS  = 8'd43;
    localparam logic [7:0] CHAR_MINUS = 8'd45;

    localparam logic [1:0] SIZE_SHORT = 2'd0;
    localparam logic [1:0] SIZE_INT   = 2'd1;
    localparam logic [1:0] SIZE_LONG  = 2'd2;

    typedef logic [6:0] t_width;
    typedef logic [4:0] t_ndig;

    typedef struct packed {
        logic [63:0] value_bits;
        logic [1:0]  size_mode;
        logic        is_signed;
        logic        flag_left;
        logic        flag_plus;
        logic        flag_space;
        logic        flag_zero;
        logic [6:0]  field_width;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_char;
        logic       last_char;
    } t_out_item;

    // converted number waiting for the emitter
    typedef struct packed {
        logic [NUM_DIGITS-1:0][3:0] digits;
        t_ndig                      ndig;
        logic                       has_sign;
        logic [7:0]                 sign_char;
        logic                       left;
        logic                       zero;
        t_width                     width;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

### design/ifmt_front.sv
// front end: takes an item, works out sign and magnitude, converts to bcd
module ifmt_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  ifmt_pkg::t_in_item i_item,
    input  ifmt_pkg::t_q_stat i_q_stat,
    output logic              o_push,
    output ifmt_pkg::t_job    o_job
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_PUSH
    } t_state;

    t_state r_state, n_state;
    logic [63:0] r_bin, n_bin;
    logic [ifmt_pkg::NUM_DIGITS-1:0][3:0] r_bcd, n_bcd;
    logic [5:0] r_cnt, n_cnt;
    logic r_has_sign, n_has_sign;
    logic [7:0] r_sign_char, n_sign_char;
    logic r_left, n_left;
    logic r_zero, n_zero;
    ifmt_pkg::t_width r_width, n_width;

    logic [63:0] w_mask;
    logic [63:0] w_val;
    logic [63:0] w_mag;
    logic        w_top;
    logic        w_neg;
    logic [ifmt_pkg::NUM_DIGITS-1:0][3:0] w_adj;
    logic [4*ifmt_pkg::NUM_DIGITS-1:0]    w_adj_bits;
    ifmt_pkg::t_ndig w_ndig;

    // input masking and magnitude
    always_comb begin
        unique case (i_item.size_mode)
            ifmt_pkg::SIZE_SHORT: begin
                w_mask = 64'h0000_0000_0000_FFFF;
                w_top  = i_item.value_bits[15];
            end
            ifmt_pkg::SIZE_INT: begin
                w_mask = 64'h0000_0000_FFFF_FFFF;
                w_top  = i_item.value_bits[31];
            end
            default: begin
                w_mask = 64'hFFFF_FFFF_FFFF_FFFF;
                w_top  = i_item.value_bits[63];
            end
        endcase
        w_val = i_item.value_bits & w_mask;
        w_neg = i_item.is_signed & w_top;
        w_mag = w_neg ? ((~w_val + 64'd1) & w_mask) : w_val;
    end

    // add-3 correction on every bcd digit
    always_comb begin
        for (int i = 0; i < ifmt_pkg::NUM_DIGITS; i++) begin
            w_adj[i] = (r_bcd[i] >= 4'd5) ? (r_bcd[i] + 4'd3) : r_bcd[i];
        end
        w_adj_bits = w_adj;
    end

    // highest nonzero digit, zero prints as one digit
    always_comb begin
        w_ndig = 5'd1;
        for (int i = 0; i < ifmt_pkg::NUM_DIGITS; i++) begin
            if (r_bcd[i] != 4'd0) begin
                w_ndig = 5'(i + 1);
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_bin       = r_bin;
        n_bcd       = r_bcd;
        n_cnt       = r_cnt;
        n_has_sign  = r_has_sign;
        n_sign_char = r_sign_char;
        n_left      = r_left;
        n_zero      = r_zero;
        n_width     = r_width;
        o_push      = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_bcd = '0;
                    unique case (i_item.size_mode)
                        ifmt_pkg::SIZE_SHORT: begin
                            n_bin = {w_mag[15:0], 48'd0};
                            n_cnt = 6'd15;
                        end
                        ifmt_pkg::SIZE_INT: begin
                            n_bin = {w_mag[31:0], 32'd0};
                            n_cnt = 6'd31;
                        end
                        default: begin
                            n_bin = w_mag;
                            n_cnt = 6'd63;
                        end
                    endcase
                    n_has_sign = w_neg | (i_item.is_signed &
                                          (i_item.flag_plus | i_item.flag_space));
                    if (w_neg) begin
                        n_sign_char = ifmt_pkg::CHAR_MINUS;
                    end else if (i_item.flag_plus) begin
                        n_sign_char = ifmt_pkg::CHAR_PLUS;
                    end else begin
                        n_sign_char = ifmt_pkg::CHAR_SPACE;
                    end
                    n_left  = i_item.flag_left;
                    n_zero  = i_item.flag_zero;
                    n_width = (i_item.field_width > 7'(ifmt_pkg::MAX_WIDTH)) ?
                              7'(ifmt_pkg::MAX_WIDTH) : i_item.field_width;
                    n_state = ST_CONV;
                end
            end
            ST_CONV: begin
                // top bit of the top digit never fills for a 64-bit magnitude
                n_bcd = {w_adj_bits[4*ifmt_pkg::NUM_DIGITS-2:0], r_bin[63]};
                n_bin = {r_bin[62:0], 1'b0};
                n_cnt = r_cnt - 6'd1;
                if (r_cnt == 6'd0) begin
                    n_state = ST_PUSH;
                end
            end
            ST_PUSH: begin
                if (!i_q_stat.full) begin
                    o_push  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_job.digits    = r_bcd;
        o_job.ndig      = w_ndig;
        o_job.has_sign  = r_has_sign;
        o_job.sign_char = r_sign_char;
        o_job.left      = r_left;
        o_job.zero      = r_zero;
        o_job.width     = r_width;
    end

    assign busy = (r_state != ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_bin       <= n_bin;
        r_bcd       <= n_bcd;
        r_cnt       <= n_cnt;
        r_has_sign  <= n_has_sign;
        r_sign_char <= n_sign_char;
        r_left      <= n_left;
        r_zero      <= n_zero;
        r_width     <= n_width;
    end

endmodule

### design/ifmt_queue.sv
// two-entry queue of converted numbers between front and back
module ifmt_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  ifmt_pkg::t_job    i_job,
    input  logic              i_pop,
    output ifmt_pkg::t_job    o_job,
    output ifmt_pkg::t_q_stat o_stat
);

    ifmt_pkg::t_job r_mem [ifmt_pkg::QDEPTH];
    logic r_wptr, n_wptr;
    logic r_rptr, n_rptr;
    logic [1:0] r_count, n_count;

    always_comb begin
        n_wptr  = r_wptr ^ i_push;
        n_rptr  = r_rptr ^ i_pop;
        n_count = r_count + {1'b0, i_push} - {1'b0, i_pop};
    end

    assign o_job        = r_mem[r_rptr];
    assign o_stat.full  = (r_count == 2'(ifmt_pkg::QDEPTH));
    assign o_stat.empty = (r_count == 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

endmodule

### design/ifmt_back.sv
// back end: lays out padding, sign and digits and emits one char per cycle
module ifmt_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ifmt_pkg::t_job      i_job,
    input  ifmt_pkg::t_q_stat   i_q_stat,
    output logic                o_pop,
    output logic                o_strobe,
    output ifmt_pkg::t_out_item o_result
);

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    t_state r_state, n_state;
    ifmt_pkg::t_width r_pos, n_pos;
    ifmt_pkg::t_width r_lead, n_lead;
    ifmt_pkg::t_width r_zend, n_zend;
    ifmt_pkg::t_width r_dend, n_dend;
    ifmt_pkg::t_width r_total, n_total;
    logic [ifmt_pkg::NUM_DIGITS-1:0][3:0] r_digits, n_digits;
    logic r_has_sign, n_has_sign;
    logic [7:0] r_sign_char, n_sign_char;
    logic r_strobe, n_strobe;
    ifmt_pkg::t_out_item r_result, n_result;

    ifmt_pkg::t_width w_len, w_pad, w_lead, w_zpad, w_zend;
    logic [4:0] w_didx;
    logic [7:0] w_char;

    // segment boundaries of the next job
    always_comb begin
        w_len  = 7'(i_job.ndig) + 7'(i_job.has_sign);
        w_pad  = (i_job.width > w_len) ? (i_job.width - w_len) : 7'd0;
        w_lead = (!i_job.left && !i_job.zero) ? w_pad : 7'd0;
        w_zpad = (!i_job.left && i_job.zero) ? w_pad : 7'd0;
        w_zend = w_lead + 7'(i_job.has_sign) + w_zpad;
    end

    // character at the current position
    always_comb begin
        w_didx = 5'(r_dend - r_pos - 7'd1);
        if (r_pos < r_lead) begin
            w_char = ifmt_pkg::CHAR_SPACE;
        end else if (r_has_sign && (r_pos == r_lead)) begin
            w_char = r_sign_char;
        end else if (r_pos < r_zend) begin
            w_char = ifmt_pkg::CHAR_ZERO;
        end else if (r_pos < r_dend) begin
            w_char = ifmt_pkg::CHAR_ZERO + {4'd0, r_digits[w_didx]};
        end else begin
            w_char = ifmt_pkg::CHAR_SPACE;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_pos       = r_pos;
        n_lead      = r_lead;
        n_zend      = r_zend;
        n_dend      = r_dend;
        n_total     = r_total;
        n_digits    = r_digits;
        n_has_sign  = r_has_sign;
        n_sign_char = r_sign_char;
        n_strobe    = 1'b0;
        n_result    = r_result;
        o_pop       = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (!i_q_stat.empty) begin
                    o_pop       = 1'b1;
                    n_pos       = 7'd0;
                    n_lead      = w_lead;
                    n_zend      = w_zend;
                    n_dend      = w_zend + 7'(i_job.ndig);
                    n_total     = w_len + w_pad;
                    n_digits    = i_job.digits;
                    n_has_sign  = i_job.has_sign;
                    n_sign_char = i_job.sign_char;
                    n_state     = ST_RUN;
                end
            end
            ST_RUN: begin
                n_strobe           = 1'b1;
                n_result.out_char  = w_char;
                n_result.last_char = (r_pos == (r_total - 7'd1));
                n_pos              = r_pos + 7'd1;
                if (r_pos == (r_total - 7'd1)) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
        end
        r_pos       <= n_pos;
        r_lead      <= n_lead;
        r_zend      <= n_zend;
        r_dend      <= n_dend;
        r_total     <= n_total;
        r_digits    <= n_digits;
        r_has_sign  <= n_has_sign;
        r_sign_char <= n_sign_char;
        r_result    <= n_result;
    end

endmodule

### design/integer_decimal_formatter_unit.sv
// top level of the integer decimal formatter
//
// Formats one integer per item as printf-style decimal text (%d / %u with the
// left, plus, space and zero flags and a field width clamped to 64) and emits
// it one ASCII character per strobe, with last_char set on the final one. An
// item is taken when start is high and busy is low. Results cannot be held
// off: each character is valid for exactly the one cycle its strobe is high.
// The front end converts the magnitude to bcd with a shift-and-add-3 loop, one
// input bit per cycle, so busy stays high while every bit of the short, int or
// long magnitude is shifted in and through the hand-off state, and longer while
// the queue is full. The back end emits max(field width, text length)
// characters, one per cycle, and then returns to idle to fetch the next number.
// A two-entry queue sits between them, so a new number is converted while the
// previous one is still being sent out; sustained throughput is set by the
// slower of the two.
module integer_decimal_formatter_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  ifmt_pkg::t_in_item  i_item,
    output logic                o_strobe,
    output ifmt_pkg::t_out_item o_result
);

    logic              w_push;
    logic              w_pop;
    ifmt_pkg::t_job    w_job_in;
    ifmt_pkg::t_job    w_job_out;
    ifmt_pkg::t_q_stat w_q_stat;

    // front end: sign, magnitude and binary to bcd conversion
    ifmt_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .i_q_stat (w_q_stat),
        .o_push   (w_push),
        .o_job    (w_job_in)
    );

    // decouples conversion from emission
    ifmt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job_in),
        .i_pop   (w_pop),
        .o_job   (w_job_out),
        .o_stat  (w_q_stat)
    );

    // back end: padding, sign and digits out one per cycle
    ifmt_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_job    (w_job_out),
        .i_q_stat (w_q_stat),
        .o_pop    (w_pop),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    // front end never pushes into a full queue
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_q_stat.full)
        else $error("push into full queue");

    // back end never pops an empty queue
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_q_stat.empty)
        else $error("pop from empty queue");

    // an accepted item keeps the front end busy for conversion
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("front end not busy after accept");

    // a finished number is followed by a gap before the next one
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.last_char) |=> !o_strobe)
        else $error("strobe right after last character");

endmodule
